// ===== rtl/vfv_pkg.sv =====
// Shared constants, types and address helper for the voxel face visibility block.
package vfv_pkg;

   localparam int CHUNK_EDGE = 16;
   localparam int CELL_COUNT = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COORD_W    = 4;
   localparam int NB_W       = COORD_W + 1;
   localparam int MASK_W     = 6;
   localparam int PROBE_W    = 3;

   // item function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // probe sequence of a query: centre cell first, then the six neighbours
   localparam logic [PROBE_W-1:0] PROBE_CENTRE = 3'd0;
   localparam logic [PROBE_W-1:0] PROBE_LEFT   = 3'd1;
   localparam logic [PROBE_W-1:0] PROBE_RIGHT  = 3'd2;
   localparam logic [PROBE_W-1:0] PROBE_BOTTOM = 3'd3;
   localparam logic [PROBE_W-1:0] PROBE_TOP    = 3'd4;
   localparam logic [PROBE_W-1:0] PROBE_BACK   = 3'd5;
   localparam logic [PROBE_W-1:0] PROBE_FRONT  = 3'd6;

   typedef struct packed {
      logic                  load;
      logic                  mem_we;
      logic                  mem_clr;
      logic                  mem_re;
      logic [PROBE_W-1:0]    probe;
      logic [ADDR_W-1:0]     clr_addr;
      logic                  commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [NB_W-1:0] x,
                                                   input logic [NB_W-1:0] y,
                                                   input logic [NB_W-1:0] z);
      logic [31:0] a;
      a = (32'(x) * 32'(CHUNK_EDGE) + 32'(y)) * 32'(CHUNK_EDGE) + 32'(z);
      return a[ADDR_W-1:0];
   endfunction

endpackage

// ===== rtl/vfv_ctrl.sv =====
// Sequencer for the voxel face visibility block: clear pass, writes and query probes.
module vfv_ctrl import vfv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_func,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_WRITE  = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(CELL_COUNT - 1);

   logic [2:0]         state_ff, state_in;
   logic [PROBE_W-1:0] probe_ff, probe_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic               accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      probe_in     = probe_ff;
      clr_in       = clr_ff;
      cmd          = '0;
      cmd.probe    = probe_ff;
      cmd.clr_addr = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.mem_clr = 1'b1;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               probe_in = PROBE_CENTRE;
               state_in = (req_func == FUNC_QUERY) ? ST_READ : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.mem_we = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_READ: begin
            cmd.mem_re = 1'b1;
            probe_in   = probe_ff + 1'b1;
            if (probe_ff == PROBE_FRONT) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the result register can take the item
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         probe_ff <= PROBE_CENTRE;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         probe_ff <= probe_in;
         clr_ff   <= clr_in;
      end
   end

endmodule

// ===== rtl/vfv_dp.sv =====
// Datapath: item registers, occupancy bitmap, neighbour addressing and face mask build.
module vfv_dp import vfv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_func,
   input  logic [COORD_W-1:0] req_coord_x,
   input  logic [COORD_W-1:0] req_coord_y,
   input  logic [COORD_W-1:0] req_coord_z,
   input  logic               req_occupied,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [MASK_W-1:0]  rsp_face_mask,
   input  cmd_type            cmd,
   output status_type         status
);

   logic                 occ_mem [CELL_COUNT];

   logic                 query_ff;
   logic [COORD_W-1:0]   x_ff, y_ff, z_ff;
   logic                 occ_ff;
   logic                 inside_ff, inside_in;
   logic                 rd_data_ff;
   logic                 pend_valid_ff;
   logic [PROBE_W-1:0]   pend_probe_ff;
   logic                 pend_live_ff;
   logic                 centre_ff, centre_in;
   logic [MASK_W-1:0]    mask_ff, mask_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]    rsp_mask_ff;

   logic [NB_W-1:0]      nb_x, nb_y, nb_z;
   logic                 nb_live;
   logic [ADDR_W-1:0]    mem_addr;
   logic                 mem_wr;
   logic                 mem_bit;

   assign inside_in = (32'(req_coord_x) < 32'(CHUNK_EDGE)) &&
                      (32'(req_coord_y) < 32'(CHUNK_EDGE)) &&
                      (32'(req_coord_z) < 32'(CHUNK_EDGE));

   // neighbour coordinates and whether that face lies inside the chunk
   always_comb begin
      nb_x    = {1'b0, x_ff};
      nb_y    = {1'b0, y_ff};
      nb_z    = {1'b0, z_ff};
      nb_live = 1'b0;
      unique case (cmd.probe)
         PROBE_CENTRE: nb_live = 1'b1;
         PROBE_LEFT: begin
            nb_x    = {1'b0, x_ff} - 1'b1;
            nb_live = (x_ff != '0);
         end
         PROBE_RIGHT: begin
            nb_x    = {1'b0, x_ff} + 1'b1;
            nb_live = 32'(x_ff) < 32'(CHUNK_EDGE - 1);
         end
         PROBE_BOTTOM: begin
            nb_y    = {1'b0, y_ff} - 1'b1;
            nb_live = (y_ff != '0);
         end
         PROBE_TOP: begin
            nb_y    = {1'b0, y_ff} + 1'b1;
            nb_live = 32'(y_ff) < 32'(CHUNK_EDGE - 1);
         end
         PROBE_BACK: begin
            nb_z    = {1'b0, z_ff} - 1'b1;
            nb_live = (z_ff != '0);
         end
         PROBE_FRONT: begin
            nb_z    = {1'b0, z_ff} + 1'b1;
            nb_live = 32'(z_ff) < 32'(CHUNK_EDGE - 1);
         end
         default: nb_live = 1'b0;
      endcase
   end

   // single port: clear sweep, item write or probe read
   assign mem_wr   = cmd.mem_clr || (cmd.mem_we && inside_ff);
   assign mem_bit  = cmd.mem_clr ? 1'b0 : occ_ff;
   assign mem_addr = cmd.mem_clr ? cmd.clr_addr : cell_addr(nb_x, nb_y, nb_z);

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         occ_mem[mem_addr] <= mem_bit;
      end else if (cmd.mem_re) begin
         rd_data_ff <= occ_mem[mem_addr];
      end
   end

   // fold the bit read in the previous cycle into centre flag and face mask
   always_comb begin
      centre_in = centre_ff;
      mask_in   = mask_ff;
      if (pend_valid_ff) begin
         if (pend_probe_ff == PROBE_CENTRE) begin
            centre_in = rd_data_ff && inside_ff;
         end else if (pend_live_ff && !rd_data_ff) begin
            mask_in[pend_probe_ff - PROBE_LEFT] = 1'b1;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in    = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         query_ff  <= (req_func == FUNC_QUERY);
         x_ff      <= req_coord_x;
         y_ff      <= req_coord_y;
         z_ff      <= req_coord_z;
         occ_ff    <= req_occupied;
         inside_ff <= inside_in;
         centre_ff <= 1'b0;
         mask_ff   <= '0;
      end else begin
         centre_ff <= centre_in;
         mask_ff   <= mask_in;
      end
      pend_probe_ff <= cmd.probe;
      pend_live_ff  <= nb_live;
      if (cmd.commit) begin
         rsp_mask_ff <= (query_ff && centre_in) ? mask_in : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= cmd.mem_re;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_face_mask = rsp_mask_ff;

endmodule

// ===== rtl/voxel_face_visibility_mask_core.sv =====
// Top level of the voxel face visibility block: sequencer plus bitmap datapath.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_func, req_coord_x/y/z, req_occupied
//   rsp      out        rsp_valid/rsp_stall  rsp_face_mask
//
// A query reads the single-port occupancy bitmap one read per cycle for the cell
// and its six neighbours, then folds in the last read and commits the result; a
// write stores the occupancy bit of its cell and commits. After reset a clearing
// pass empties the bitmap one cell a cycle, all CELL_COUNT (4096) cells, while
// req_stall stays high.
// A finished item waits in the result register; a stalled result holds the block
// in its final step, but the next item may be accepted as soon as it is loaded.
module voxel_face_visibility_mask_core import vfv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [COORD_W-1:0] req_coord_x,
   input  logic [COORD_W-1:0] req_coord_y,
   input  logic [COORD_W-1:0] req_coord_z,
   input  logic               req_occupied,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [MASK_W-1:0]  rsp_face_mask
);

   cmd_type    cmd;
   status_type status;

   // sequence clear, write and probe steps
   vfv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the item, drive the bitmap, build the mask and register the result
   vfv_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_func      (req_func),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .req_coord_z   (req_coord_z),
      .req_occupied  (req_occupied),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_face_mask (rsp_face_mask),
      .cmd           (cmd),
      .status        (status)
   );

endmodule
